// ----- hdl/pcw_pkg.sv -----
// ----------------------------------------------------------------------------
// pcw_pkg: shared types and constants of the pin change watch table
// Holds the table sizes, the operation and edge mode codes, the entry layout
// and the memory port structures used across the block.
// ----------------------------------------------------------------------------
package pcw_pkg;

    localparam int MAX_WATCHES = 16;
    localparam int PIN_COUNT   = 64;

    localparam int IDX_W = (MAX_WATCHES > 1) ? $clog2(MAX_WATCHES) : 1;
    localparam int CNT_W = $clog2(MAX_WATCHES + 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ARM   = 2'd1,
        OP_TICK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        EDGE_ANY  = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } t_edge;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARM,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [5:0]  pin;
        logic [1:0]  edge_mode;
        logic [31:0] debounce;
        logic [15:0] thread;
        logic        level;
        logic [31:0] change_time;
        logic        triggered;
        logic        ready;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_ram_rd;

    // Level of one pin; pins beyond the pin count read as low.
    function automatic logic level_of(logic [63:0] levels, logic [5:0] pin);
        logic lvl;
        lvl = 1'b0;
        if (int'(pin) < PIN_COUNT) begin
            lvl = levels[pin];
        end
        return lvl;
    endfunction

endpackage

// ----- hdl/pcw_entry_ram.sv -----
// ----------------------------------------------------------------------------
// pcw_entry_ram: watch entry storage
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read is issued and holds until the next read.
// ----------------------------------------------------------------------------
module pcw_entry_ram (
    input  logic               i_clk,
    input  pcw_pkg::t_ram_wr   i_wr,
    input  pcw_pkg::t_ram_rd   i_rd,
    output pcw_pkg::t_entry    o_rd_data
);

    pcw_pkg::t_entry r_mem [pcw_pkg::MAX_WATCHES];
    pcw_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/pcw_eval.sv -----
// ----------------------------------------------------------------------------
// pcw_eval: debounced edge evaluation of one watch entry
// Applies the debounce test and the edge mode to one entry for a tick and
// returns the updated entry and whether the watch fires.
// ----------------------------------------------------------------------------
module pcw_eval (
    input  pcw_pkg::t_entry i_entry,
    input  logic [31:0]     i_now,
    input  logic [63:0]     i_levels,
    output pcw_pkg::t_entry o_entry,
    output logic            o_fire
);

    logic [31:0] elapsed;
    logic        sample;
    logic        new_lvl;
    logic        trig;

    always_comb begin
        elapsed = i_now - i_entry.change_time;
        sample  = (elapsed > i_entry.debounce);
        new_lvl = pcw_pkg::level_of(i_levels, i_entry.pin);
        o_entry = i_entry;
        trig    = i_entry.triggered;
        if (sample) begin
            case (i_entry.edge_mode)
                pcw_pkg::EDGE_ANY:  trig = (i_entry.level != new_lvl);
                pcw_pkg::EDGE_RISE: trig = !i_entry.level && new_lvl;
                pcw_pkg::EDGE_FALL: trig = i_entry.level && !new_lvl;
                default:            trig = i_entry.triggered;
            endcase
            if (i_entry.level != new_lvl) begin
                o_entry.level       = new_lvl;
                o_entry.change_time = i_now;
            end
        end
        o_fire            = i_entry.ready && trig;
        o_entry.triggered = o_fire ? 1'b0 : trig;
        o_entry.ready     = o_fire ? 1'b0 : i_entry.ready;
    end

endmodule

// ----- hdl/pin_change_watch_table.sv -----
// ----------------------------------------------------------------------------
// pin_change_watch_table: table of debounced pin change watches
// Stores pin watches in an entry memory and walks them on every tick,
// emitting the thread of each watch that fires.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An add or a clear completes
// without leaving the idle state. An arm walks the table from slot zero
// until it finds the first watch of the thread, one entry per cycle. A tick
// walks every stored entry through the registered read of the entry memory,
// one entry per cycle while the walk is not paused, and then releases its
// final result in a closing state. Each watch that fires produces one
// result transaction with its thread and table slot; the last result of a
// tick is marked with o_last, and a tick in which nothing fires produces no
// result. Because the last flag needs to know that nothing else fires, each
// result is held back until the next firing watch or the end of the walk. A
// stalled output pauses the walk only when a watch fires while one result
// still sits in the output register and another is held back; the closing
// state likewise waits until the held result can move to the output. An add
// on a full table is ignored, and an arm for a thread with no watch changes
// nothing.
// ----------------------------------------------------------------------------
module pin_change_watch_table (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_pin_index,
    input  logic [1:0]  i_edge_mode,
    input  logic [31:0] i_debounce_ms,
    input  logic [15:0] i_thread_id,
    input  logic [31:0] i_now_ms,
    input  logic [63:0] i_pin_levels,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_run_thread,
    output logic [3:0]  o_entry_slot,
    output logic        o_last
);

    localparam int IDX_W = pcw_pkg::IDX_W;
    localparam int CNT_W = pcw_pkg::CNT_W;

    pcw_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_cur, n_cur;

    // Operands of the transaction being worked on.
    logic [15:0]      r_thr;
    logic [31:0]      r_now;
    logic [63:0]      r_levels;

    // A fired watch held back until it is known whether it is the last.
    logic             r_pend_valid, n_pend_valid;
    logic [15:0]      r_pend_thread, n_pend_thread;
    logic [IDX_W-1:0] r_pend_slot, n_pend_slot;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_thread, n_out_thread;
    logic [3:0]       r_out_slot, n_out_slot;
    logic             r_out_last, n_out_last;

    pcw_pkg::t_ram_wr ram_wr;
    pcw_pkg::t_ram_rd ram_rd;
    pcw_pkg::t_entry  rd_entry;
    pcw_pkg::t_entry  upd_entry;
    logic             fire;

    logic             accept;
    logic             out_free;
    logic             last_entry;

    pcw_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (rd_entry)
    );

    pcw_eval u_eval (
        .i_entry  (rd_entry),
        .i_now    (r_now),
        .i_levels (r_levels),
        .o_entry  (upd_entry),
        .o_fire   (fire)
    );

    assign o_stall    = (r_state != pcw_pkg::S_IDLE);
    assign accept     = i_valid && !o_stall;
    // The output register can take a new result when it is empty or being taken.
    assign out_free   = !r_out_valid || !i_stall;
    assign last_entry = ((CNT_W'(r_cur) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cur         = r_cur;
        n_pend_valid  = r_pend_valid;
        n_pend_thread = r_pend_thread;
        n_pend_slot   = r_pend_slot;
        n_out_valid   = r_out_valid && i_stall;
        n_out_thread  = r_out_thread;
        n_out_slot    = r_out_slot;
        n_out_last    = r_out_last;
        ram_wr        = '0;
        ram_rd.en     = 1'b0;
        ram_rd.addr   = r_cur + IDX_W'(1);

        case (r_state)
            pcw_pkg::S_IDLE: begin
                if (accept) begin
                    case (pcw_pkg::t_op'(i_operation))
                        pcw_pkg::OP_ADD: begin
                            if (int'(r_count) < pcw_pkg::MAX_WATCHES) begin
                                ram_wr.en               = 1'b1;
                                ram_wr.addr             = IDX_W'(r_count);
                                ram_wr.data.pin         = i_pin_index;
                                ram_wr.data.edge_mode   = i_edge_mode;
                                ram_wr.data.debounce    = i_debounce_ms;
                                ram_wr.data.thread      = i_thread_id;
                                ram_wr.data.level       =
                                    pcw_pkg::level_of(i_pin_levels, i_pin_index);
                                ram_wr.data.change_time = '0;
                                ram_wr.data.triggered   = 1'b0;
                                ram_wr.data.ready       = 1'b0;
                                n_count                 = r_count + CNT_W'(1);
                            end
                        end
                        pcw_pkg::OP_ARM: begin
                            if (r_count != '0) begin
                                ram_rd.en   = 1'b1;
                                ram_rd.addr = '0;
                                n_cur       = '0;
                                n_state     = pcw_pkg::S_ARM;
                            end
                        end
                        pcw_pkg::OP_TICK: begin
                            if (r_count != '0) begin
                                ram_rd.en   = 1'b1;
                                ram_rd.addr = '0;
                                n_cur       = '0;
                                n_state     = pcw_pkg::S_SCAN;
                            end
                        end
                        pcw_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end

            pcw_pkg::S_ARM: begin
                // Only the first watch of the thread is armed.
                if (rd_entry.thread == r_thr) begin
                    ram_wr.en         = 1'b1;
                    ram_wr.addr       = r_cur;
                    ram_wr.data       = rd_entry;
                    ram_wr.data.ready = 1'b1;
                    n_state           = pcw_pkg::S_IDLE;
                end else if (last_entry) begin
                    n_state = pcw_pkg::S_IDLE;
                end else begin
                    ram_rd.en = 1'b1;
                    n_cur     = r_cur + IDX_W'(1);
                end
            end

            pcw_pkg::S_SCAN: begin
                // Hold this entry while it fires and a held result cannot move to the output.
                if (!(fire && r_pend_valid && !out_free)) begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = r_cur;
                    ram_wr.data = upd_entry;
                    if (fire) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_thread = r_pend_thread;
                            n_out_slot   = 4'(r_pend_slot);
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_thread = rd_entry.thread;
                        n_pend_slot   = r_cur;
                    end
                    if (last_entry) begin
                        n_state = pcw_pkg::S_FLUSH;
                    end else begin
                        ram_rd.en = 1'b1;
                        n_cur     = r_cur + IDX_W'(1);
                    end
                end
            end

            pcw_pkg::S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = pcw_pkg::S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_thread = r_pend_thread;
                    n_out_slot   = 4'(r_pend_slot);
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = pcw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pcw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pcw_pkg::S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_pend_thread <= n_pend_thread;
        r_pend_slot   <= n_pend_slot;
        r_out_thread  <= n_out_thread;
        r_out_slot    <= n_out_slot;
        r_out_last    <= n_out_last;
        if (accept) begin
            r_thr    <= i_thread_id;
            r_now    <= i_now_ms;
            r_levels <= i_pin_levels;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_run_thread = r_out_thread;
    assign o_entry_slot = r_out_slot;
    assign o_last       = r_out_last;

endmodule
